### sv/swtd_pkg.sv
package swtd_pkg;

	localparam int unsigned DATA_W     = 16;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned WINDOW_DEF = 16;

	localparam logic [CFG_W-1:0] RUN_MAX        = 16'hFFFF;
	localparam logic [CFG_W-1:0] STABLE_DEV_RST = 16'd1;
	localparam logic [CFG_W-1:0] TREND_LEN_RST  = 16'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STABLE_DEV = 1'b0,
		REG_TREND_LEN  = 1'b1
	} cfg_reg_t;

endpackage

### sv/sliding_window_trend_detector.sv
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// input     | in_valid / in_stall       | mode, sample
// result    | out_valid / out_stall     | ready_res, minimum, maximum, mean, deviation,
//           |                           | is_stable, is_rising, is_falling
// config    | wr_en                     | wr_index, wr_data
//
// Filling and restart items go straight to the output state. Once the window is full an item
// takes a serial read of every window entry through the single memory read port, a
// reciprocal-multiply divider by WINDOW for the mean, a serial square root, then the
// same divider for the deviation.
// Reset clears pointers, fill count, run counters and held statistics; the window memory
// is not cleared. One item is in work at a time; a new item is taken while a result waits.
module sliding_window_trend_detector #(
	parameter int unsigned WINDOW = swtd_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic signed [15:0]            sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ready_res,
	output logic signed [15:0]            minimum,
	output logic signed [15:0]            maximum,
	output logic signed [15:0]            mean,
	output logic [15:0]                   deviation,
	output logic                          is_stable,
	output logic                          is_rising,
	output logic                          is_falling,
	input  logic                          wr_en,
	input  logic [swtd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [swtd_pkg::CFG_W-1:0]    wr_data
);

	localparam int unsigned LW   = $clog2(WINDOW);
	localparam int unsigned CW   = $clog2(WINDOW + 1);
	localparam int unsigned SUMW = 17 + LW;
	localparam int unsigned SQW  = 32 + LW;
	localparam int unsigned VW   = 32 + 2 * LW;
	localparam int unsigned RW   = VW / 2;
	localparam int unsigned NN   = WINDOW * WINDOW;
	localparam int unsigned BIAS = WINDOW * 32768;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_MUL, ST_VAR, ST_MEAN, ST_SQRT, ST_DEV, ST_CLASS, ST_OUT
	} state_t;

	state_t state_q;

	logic [15:0]   stable_dev_q, trend_len_q;
	logic [LW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic [15:0]   stable_run_q, rising_run_q, falling_run_q;
	logic signed [15:0] min_q, max_q, mean_q, newest_q, oldest_q;
	logic [15:0]   dev_q;

	// scan pipeline
	logic          rd_busy_q;
	logic [LW-1:0] rd_addr_q;
	logic          v_s1, first_s1, last_s1, old_s1;
	logic          v_s2, first_s2, last_s2, old_s2;
	logic signed [15:0] d_s2;
	logic [31:0]   sq_s2;
	logic signed [SUMW-1:0] sum_q;
	logic [SQW-1:0] sumsq_q;

	logic [2*SUMW-1:0]     sum2_q;
	logic [VW-1:0]         nsq_q, var_q, bound_q;
	logic [31:0]           devsq_q;
	logic signed [SUMW-1:0] oldn_q, newn_q;

	logic          accept, out_free;
	logic [15:0]   rd_data;
	logic signed [SUMW-1:0] mean_sum;

	logic          div_start, div_done, sqrt_start, sqrt_done;
	logic [RW-1:0] div_dividend, div_quo, sqrt_root;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign mean_sum = sum_q + $signed(SUMW'(BIAS));

	swtd_mem #(.DEPTH(WINDOW), .AW(LW)) u_mem (
		.clk     (clk),
		.wr_en   (accept && !mode),
		.wr_addr (wp_q),
		.wr_data (sample),
		.rd_en   (rd_busy_q),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	assign div_start    = (state_q == ST_VAR) || (state_q == ST_SQRT && sqrt_done);
	assign div_dividend = (state_q == ST_VAR) ? mean_sum[RW-1:0] : sqrt_root;
	assign sqrt_start   = (state_q == ST_MEAN) && div_done;

	swtd_div #(.DW(RW), .DIVISOR(WINDOW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quo)
	);

	swtd_isqrt #(.VW(VW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (var_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_dev_q <= swtd_pkg::STABLE_DEV_RST;
			trend_len_q  <= swtd_pkg::TREND_LEN_RST;
		end else if (wr_en) begin
			case (wr_index)
				swtd_pkg::REG_STABLE_DEV: stable_dev_q <= wr_data;
				swtd_pkg::REG_TREND_LEN:  trend_len_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		v_s1     <= rd_busy_q;
		first_s1 <= (rd_addr_q == '0);
		last_s1  <= (rd_addr_q == LW'(WINDOW - 1));
		old_s1   <= (rd_addr_q == wp_q);
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		old_s2   <= old_s1;
		d_s2     <= rd_data;
		sq_s2    <= 32'($signed(rd_data) * $signed(rd_data));
		if (accept && !mode) begin
			newest_q <= sample;
		end
		if (v_s2) begin
			if (old_s2) begin
				oldest_q <= d_s2;
			end
			sum_q   <= (first_s2 ? '0 : sum_q) + SUMW'(d_s2);
			sumsq_q <= (first_s2 ? '0 : sumsq_q) + SQW'(sq_s2);
		end
		if (state_q == ST_MUL) begin
			sum2_q  <= (2*SUMW)'(sum_q * sum_q);
			nsq_q   <= VW'(sumsq_q) * VW'(WINDOW);
			devsq_q <= 32'(stable_dev_q) * 32'(stable_dev_q);
			oldn_q  <= SUMW'(oldest_q) * $signed(SUMW'(WINDOW));
			newn_q  <= SUMW'(newest_q) * $signed(SUMW'(WINDOW));
		end
		if (state_q == ST_VAR) begin
			var_q   <= nsq_q - sum2_q[VW-1:0];
			bound_q <= VW'(devsq_q) * VW'(NN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wp_q          <= '0;
			fill_q        <= '0;
			stable_run_q  <= '0;
			rising_run_q  <= '0;
			falling_run_q <= '0;
			min_q         <= '0;
			max_q         <= '0;
			mean_q        <= '0;
			dev_q         <= '0;
			rd_busy_q     <= 1'b0;
			rd_addr_q     <= '0;
			v_s2          <= 1'b0;
			out_valid     <= 1'b0;
			ready_res     <= 1'b0;
			minimum       <= '0;
			maximum       <= '0;
			mean          <= '0;
			deviation     <= '0;
			is_stable     <= 1'b0;
			is_rising     <= 1'b0;
			is_falling    <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			if (out_valid && !out_stall && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end
			if (rd_busy_q) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_addr_q == LW'(WINDOW - 1)) begin
					rd_busy_q <= 1'b0;
				end
			end
			if (v_s2) begin
				min_q <= (first_s2 || d_s2 < min_q) ? d_s2 : min_q;
				max_q <= (first_s2 || d_s2 > max_q) ? d_s2 : max_q;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode) begin
							wp_q          <= '0;
							fill_q        <= '0;
							stable_run_q  <= '0;
							rising_run_q  <= '0;
							falling_run_q <= '0;
							state_q       <= ST_OUT;
						end else begin
							wp_q <= (wp_q == LW'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
							if (fill_q != CW'(WINDOW)) begin
								fill_q <= fill_q + 1'b1;
							end
							if (fill_q >= CW'(WINDOW - 1)) begin
								rd_busy_q <= 1'b1;
								rd_addr_q <= '0;
								state_q   <= ST_SCAN;
							end else begin
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_SCAN: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_VAR;
				ST_VAR: state_q <= ST_MEAN;
				ST_MEAN: begin
					if (div_done) begin
						// biased quotient: flipping the top bit removes the offset
						mean_q  <= div_quo[15:0] ^ 16'h8000;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						state_q <= ST_DEV;
					end
				end
				ST_DEV: begin
					if (div_done) begin
						dev_q   <= div_quo[15:0];
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					if (var_q < bound_q) begin
						stable_run_q  <= (stable_run_q == swtd_pkg::RUN_MAX) ?
						                 stable_run_q : stable_run_q + 1'b1;
						rising_run_q  <= '0;
						falling_run_q <= '0;
					end else if (oldn_q < sum_q && sum_q < newn_q) begin
						rising_run_q  <= (rising_run_q == swtd_pkg::RUN_MAX) ?
						                 rising_run_q : rising_run_q + 1'b1;
						stable_run_q  <= '0;
						falling_run_q <= '0;
					end else if (newn_q < sum_q && sum_q < oldn_q) begin
						falling_run_q <= (falling_run_q == swtd_pkg::RUN_MAX) ?
						                 falling_run_q : falling_run_q + 1'b1;
						stable_run_q  <= '0;
						rising_run_q  <= '0;
					end else begin
						stable_run_q  <= '0;
						rising_run_q  <= '0;
						falling_run_q <= '0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						ready_res  <= (fill_q == CW'(WINDOW));
						minimum    <= min_q;
						maximum    <= max_q;
						mean       <= mean_q;
						deviation  <= dev_q;
						is_stable  <= (fill_q == CW'(WINDOW)) && (stable_run_q >= trend_len_q);
						is_rising  <= (fill_q == CW'(WINDOW)) && (rising_run_q >= trend_len_q);
						is_falling <= (fill_q == CW'(WINDOW)) && (falling_run_q >= trend_len_q);
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/swtd_mem.sv
module swtd_mem #(
	parameter int unsigned DEPTH = swtd_pkg::WINDOW_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [swtd_pkg::DATA_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [swtd_pkg::DATA_W-1:0] rd_data
);

	logic [swtd_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/swtd_div.sv
// Division by a constant through a reciprocal multiply; quotient registered in the cycle after start.
// Exact for every dividend below 2**DW.
module swtd_div #(
	parameter int unsigned DW      = 20,
	parameter int unsigned DIVISOR = swtd_pkg::WINDOW_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int unsigned SH = DW + $clog2(DIVISOR);
	localparam int unsigned MW = DW + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic [DW+MW-1:0] prod;

	assign prod = {{MW{1'b0}}, dividend} * {{DW{1'b0}}, MW'(RECIP)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quotient <= prod[SH +: DW];
		end
	end

endmodule

### sv/swtd_isqrt.sv
// Digit-by-digit integer square root, two radicand bits a cycle.
module swtd_isqrt #(
	parameter int unsigned VW = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VW-1:0]     radicand,
	output logic              done,
	output logic [VW/2-1:0]   root
);

	localparam int unsigned RW    = VW / 2;
	localparam int unsigned CNT_W = $clog2(RW);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    x_q;
	logic [RW+1:0]    rem_q;
	logic [RW+1:0]    rem_sh;
	logic [RW+1:0]    trial;

	assign rem_sh = {rem_q[RW-1:0], x_q[VW-1:VW-2]};
	assign trial  = {root, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			rem_q <= '0;
			root  <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[VW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root  <= {root[RW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root  <= {root[RW-2:0], 1'b0};
			end
		end
	end

endmodule

### sim/sliding_window_trend_detector_tb.sv
`timescale 1ns / 100ps

module sliding_window_trend_detector_tb;

	localparam int NWIN = swtd_pkg::WINDOW_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic              ready_res;
		logic signed [15:0] minimum;
		logic signed [15:0] maximum;
		logic signed [15:0] mean;
		logic [15:0]        deviation;
		logic               is_stable;
		logic               is_rising;
		logic               is_falling;
	} trend_res_t;

	class trend_scoreboard;
		logic signed [15:0] ring [NWIN];
		int unsigned wptr, fill;
		int unsigned stable_run, rising_run, falling_run;
		logic signed [15:0] h_min, h_max, h_mean;
		logic [15:0] h_dev;
		logic [15:0] dev_bound, trend_len;
		trend_res_t pending [$];
		int errors, results;

		function void clear();
			wptr = 0; fill = 0;
			stable_run = 0; rising_run = 0; falling_run = 0;
			h_min = 0; h_max = 0; h_mean = 0; h_dev = 0;
			dev_bound = swtd_pkg::STABLE_DEV_RST; trend_len = swtd_pkg::TREND_LEN_RST;
			pending.delete();
			errors = 0; results = 0;
		endfunction

		function void set_reg(swtd_pkg::cfg_reg_t idx, logic [15:0] val);
			if (idx == swtd_pkg::REG_STABLE_DEV) dev_bound = val;
			else trend_len = val;
		endfunction

		static function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned root, bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > x) bitv >>= 2;
			while (bitv != 0) begin
				if (x >= root + bitv) begin
					x -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root;
		endfunction

		function int unsigned bump(int unsigned c);
			return (c < 65535) ? c + 1 : 65535;
		endfunction

		function void rescan(logic signed [15:0] newest);
			longint s, sq, lo, hi, oldest_n, newest_n;
			longint unsigned var_num, bound;
			s = 0; sq = 0;
			lo = ring[0]; hi = ring[0];
			for (int i = 0; i < NWIN; i++) begin
				if (ring[i] < lo) lo = ring[i];
				if (ring[i] > hi) hi = ring[i];
				s += ring[i];
				sq += longint'(ring[i]) * ring[i];
			end
			h_min = 16'(lo); h_max = 16'(hi);
			h_mean = 16'((s >= 0) ? s / NWIN : -((-s + NWIN - 1) / NWIN));
			var_num = NWIN * sq - s * s;
			bound = longint'(dev_bound) * dev_bound * NWIN * NWIN;
			h_dev = 16'(int_sqrt(var_num / (NWIN * NWIN)));
			oldest_n = longint'(ring[wptr]) * NWIN;
			newest_n = longint'(newest) * NWIN;
			if (var_num < bound) begin
				stable_run = bump(stable_run); rising_run = 0; falling_run = 0;
			end else if (oldest_n < s && s < newest_n) begin
				rising_run = bump(rising_run); stable_run = 0; falling_run = 0;
			end else if (newest_n < s && s < oldest_n) begin
				falling_run = bump(falling_run); stable_run = 0; rising_run = 0;
			end else begin
				stable_run = 0; rising_run = 0; falling_run = 0;
			end
		endfunction

		function void note_item(logic restart, logic signed [15:0] smp);
			trend_res_t r;
			logic rdy;
			if (restart) begin
				wptr = 0; fill = 0;
				stable_run = 0; rising_run = 0; falling_run = 0;
			end else begin
				ring[wptr] = smp;
				wptr = (wptr + 1) % NWIN;
				if (fill < NWIN) fill++;
				if (fill >= NWIN) rescan(smp);
			end
			rdy = fill >= NWIN;
			r.ready_res = rdy;
			r.minimum = h_min; r.maximum = h_max; r.mean = h_mean; r.deviation = h_dev;
			r.is_stable = rdy && stable_run >= trend_len;
			r.is_rising = rdy && rising_run >= trend_len;
			r.is_falling = rdy && falling_run >= trend_len;
			pending.push_back(r);
		endfunction

		function void report(string fld, logic [15:0] want, logic [15:0] got);
			$display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
			errors++;
		endfunction

		function void check_result(trend_res_t got);
			trend_res_t want;
			results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.ready_res !== want.ready_res) report("ready_res", want.ready_res, got.ready_res);
			if (got.minimum !== want.minimum) report("minimum", want.minimum, got.minimum);
			if (got.maximum !== want.maximum) report("maximum", want.maximum, got.maximum);
			if (got.mean !== want.mean) report("mean", want.mean, got.mean);
			if (got.deviation !== want.deviation)
				report("deviation", want.deviation, got.deviation);
			if (got.is_stable !== want.is_stable) report("is_stable", want.is_stable, got.is_stable);
			if (got.is_rising !== want.is_rising) report("is_rising", want.is_rising, got.is_rising);
			if (got.is_falling !== want.is_falling)
				report("is_falling", want.is_falling, got.is_falling);
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, mode;
	logic signed [15:0] sample;
	logic out_valid, out_stall;
	logic r_ready, r_stable, r_rising, r_falling;
	logic signed [15:0] r_min, r_max, r_mean;
	logic [15:0] r_dev;
	trend_res_t res;
	logic wr_en;
	logic [swtd_pkg::CFG_IDX_W-1:0] wr_index;
	logic [swtd_pkg::CFG_W-1:0] wr_data;

	trend_scoreboard sb;
	int idle_cycles = 0;
	int items_sent;
	int rx_hold;
	bit rx_pause_long;

	sliding_window_trend_detector uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.ready_res(r_ready), .minimum(r_min), .maximum(r_max),
		.mean(r_mean), .deviation(r_dev), .is_stable(r_stable),
		.is_rising(r_rising), .is_falling(r_falling),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	assign res = {r_ready, r_min, r_max, r_mean, r_dev, r_stable, r_rising, r_falling};

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(120, 20);
	endfunction

	// result side: accept and check at each edge, stall for random stretches unless rx_pause_long is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold <= 0;
		end else begin
			if (out_valid && !out_stall) sb.check_result(res);
			if (rx_pause_long) begin
				out_stall <= 1'b0;
				rx_hold <= 0;
			end else if (rx_hold > 0) begin
				out_stall <= 1'b1;
				rx_hold <= rx_hold - 1;
			end else begin
				out_stall <= 1'b0;
				rx_hold <= gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_item(logic m, logic signed [15:0] s);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_item(m, s);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(swtd_pkg::cfg_reg_t idx, logic [15:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// trend-shaped random run: ramps, flats around a base, full-scale noise and extremes, rare restarts
	task automatic random_phase(int count);
		int shape, base, slope, amp, v;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				shape = $urandom_range(4);
				base = $signed($urandom_range(60000)) - 30000;
				slope = $urandom_range(50, 1);
				amp = $urandom_range(3);
			end
			case (shape)
				0: v = base + (i % 40) * slope + $signed($urandom_range(amp));
				1: v = base - (i % 40) * slope - $signed($urandom_range(amp));
				2: v = base + $signed($urandom_range(2 * amp)) - amp;
				3: v = $signed($urandom_range(65535)) - 32768;
				default: v = ($urandom_range(1)) ? 32767 : -32768;
			endcase
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			send_item($urandom_range(99) < 2, v[15:0]);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0; mode = 1'b0; sample = '0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0;
		items_sent = 0; rx_pause_long = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill with extremes, restart mid-fill, a short ramp
		write_reg(swtd_pkg::REG_TREND_LEN, 16'd1);
		write_reg(swtd_pkg::REG_STABLE_DEV, 16'd0);
		send_item(1'b1, 16'h7FFF);
		for (int i = 0; i < 5; i++) send_item(1'b0, 16'sh8000);
		send_item(1'b1, 16'h5555);
		for (int i = 0; i < NWIN; i++) send_item(1'b0, i[0] ? 16'sh7FFF : 16'sh8000);
		for (int i = 0; i < 3; i++) send_item(1'b0, 16'(1000 * i));
		drain();

		write_reg(swtd_pkg::REG_STABLE_DEV, 16'hFFFF);
		write_reg(swtd_pkg::REG_TREND_LEN, 16'd0);
		random_phase(120);
		drain();

		write_reg(swtd_pkg::REG_STABLE_DEV, 16'd4);
		write_reg(swtd_pkg::REG_TREND_LEN, 16'd3);
		random_phase(400);
		// hold off the sender until the block has caught up
		drain();
		rx_pause_long = 1'b1;
		random_phase(100);
		rx_pause_long = 1'b0;
		drain();

		write_reg(swtd_pkg::REG_STABLE_DEV, 16'd0);
		write_reg(swtd_pkg::REG_TREND_LEN, 16'hFFFF);
		random_phase(200);
		drain();
		write_reg(swtd_pkg::REG_STABLE_DEV, 16'd40);
		write_reg(swtd_pkg::REG_TREND_LEN, 16'd10);
		random_phase(200);
		drain();

		$display("Covered %0d items (fill, restart, ramps, flats, noise, extremes)",
			items_sent);
		$display("over register settings from zero to full scale; %0d results checked",
			sb.results);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
sv/swtd_pkg.sv
sv/swtd_mem.sv
sv/swtd_div.sv
sv/swtd_isqrt.sv
sv/sliding_window_trend_detector.sv
sim/sliding_window_trend_detector_tb.sv
